FILE: sv/stbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

	// Item kinds
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// One input word
	typedef struct packed {
		logic               mode;
		logic [9:0]         entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] search_key;
		logic [10:0]        range_start;
		logic [10:0]        range_end;
	} stbs_item_t;

	// One result word
	typedef struct packed {
		logic       found;
		logic [9:0] match_index;
	} stbs_result_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // write one table entry
		logic init;       // take key and bounds from the item
		logic probe;      // narrow the bounds from the current compare
		logic rd;         // issue a table read at the new midpoint
		logic res_set;    // capture the result word
		logic res_found;  // captured result is a match
	} stbs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;    // key equals the probed entry
		logic empty;  // bounds after this cycle leave no entry
	} stbs_sts_t;

endpackage

`default_nettype wire

FILE: sv/sorted_table_binary_search_core.sv
// Load word: taken from idle, gives no result; busy stays low.
// Search word: one table probe per cycle, n = 0..log2(TABLE_DEPTH)+1 probes
// (11 at 1024 entries); done registers res_set; busy is high while probing.
// Throughput is set by the compare-and-halve loop around the table read port.
// done is a one-cycle strobe; the receiver cannot stall it.
// arst_n clears the controller; the table holds no reset value until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search_core #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_BITS  = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire stbs_pkg::stbs_item_t item,
	output logic                      busy,
	output logic                      done,
	output stbs_pkg::stbs_result_t    result
);
	import stbs_pkg::*;

	stbs_cmd_t cmd;
	stbs_sts_t sts;

	stbs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	stbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_BITS  (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: sv/stbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/stbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                mode,
	input  wire stbs_pkg::stbs_sts_t sts,
	output stbs_pkg::stbs_cmd_t      cmd,
	output logic                     busy,
	output logic                     done
);
	import stbs_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;

	// Decode commands for this cycle
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && mode == MODE_LOAD) begin
					cmd.load = 1'b1;
				end else if (accept && mode == MODE_SEARCH) begin
					cmd.init = 1'b1;
					cmd.rd   = 1'b1;
					if (sts.empty) begin
						cmd.res_set = 1'b1;
					end else begin
						state_d = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				if (sts.hit) begin
					cmd.res_set   = 1'b1;
					cmd.res_found = 1'b1;
					state_d       = ST_IDLE;
				end else if (sts.empty) begin
					cmd.res_set = 1'b1;
					state_d     = ST_IDLE;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.res_set;
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while a search is still running");

	a_probe_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE && !sts.hit && !sts.empty) |=> state_q == ST_PROBE)
		else $error("search left before the range was exhausted");

	a_result_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_set |=> done_q)
		else $error("finished search gave no result strobe");

	a_init_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.init || cmd.load) |-> state_q == ST_IDLE)
		else $error("new word taken while busy");

endmodule

`default_nettype wire

FILE: sv/stbs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module stbs_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_BITS  = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stbs_pkg::stbs_item_t item,
	input  wire stbs_pkg::stbs_cmd_t  cmd,
	output stbs_pkg::stbs_sts_t       sts,
	output stbs_pkg::stbs_result_t    result
);
	import stbs_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int RW    = $clog2(TABLE_DEPTH + 1);

	logic [VALUE_BITS-1:0] key_q;
	logic [RW-1:0]         lo_q;
	logic [RW-1:0]         hi_q;
	logic [IDX_W-1:0]      mid_q;
	stbs_result_t          result_q;

	logic [31:0]           start32;
	logic [31:0]           end32;
	logic [31:0]           hsat32;
	logic [RW-1:0]         lo_n;
	logic [RW-1:0]         hi_n;
	logic [RW:0]           sum;
	logic [IDX_W-1:0]      addr;
	logic [VALUE_BITS-1:0] rdata;
	logic [VALUE_BITS-1:0] wval;
	logic                  we;
	logic                  gt;

	// Bring a 32-bit signed field to the table width
	assign wval = VALUE_BITS'(64'($signed(item.entry_value)));
	assign we   = cmd.load && (32'(item.entry_index) < 32'(TABLE_DEPTH));

	// Clamp the end of the search range to the table depth
	assign start32 = 32'(item.range_start);
	assign end32   = 32'(item.range_end);
	assign hsat32  = (end32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : end32;

	// Compare key with the probed entry
	assign sts.hit = (key_q == rdata);
	assign gt      = ($signed(key_q) > $signed(rdata));

	// Narrow the bounds
	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (cmd.init) begin
			lo_n = RW'(start32);
			hi_n = RW'(hsat32);
		end else if (cmd.probe && !sts.hit) begin
			if (gt) begin
				lo_n = RW'(mid_q) + RW'(1);
			end else begin
				hi_n = RW'(mid_q);
			end
		end
	end

	assign sts.empty = cmd.init ? (start32 >= hsat32) : (lo_n >= hi_n);

	// Next midpoint drives the table read
	assign sum  = {1'b0, lo_n} + {1'b0, hi_n};
	assign addr = sum[IDX_W:1];

	stbs_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (IDX_W'(item.entry_index)),
		.wdata (wval),
		.re    (cmd.rd),
		.raddr (addr),
		.rdata (rdata)
	);

	// Hold key, bounds and probe index
	always_ff @(posedge clk) begin
		lo_q <= lo_n;
		hi_q <= hi_n;
		if (cmd.init) begin
			key_q <= VALUE_BITS'(64'($signed(item.search_key)));
		end
		if (cmd.rd) begin
			mid_q <= addr;
		end
	end

	// Capture the result word
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			result_q.found       <= cmd.res_found;
			result_q.match_index <= cmd.res_found ? 10'(mid_q) : 10'd0;
		end
	end

	assign result = result_q;

	a_probe_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> lo_q < hi_q)
		else $error("probe with an empty range");

	a_mid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe |-> (RW'(mid_q) >= lo_q) && (RW'(mid_q) < hi_q))
		else $error("probe index outside the live range");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_set && !cmd.res_found) |=> result_q.match_index == 10'd0 && !result_q.found)
		else $error("not-found result carries an index");

endmodule

`default_nettype wire
